// ----- hw/rtl/iopfc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I/O port pin function controller package
// Commands, register decode tables, masks and pin function codes.
// ----------------------------------------------------------------------------
package iopfc_pkg;

  localparam int NumPorts = 6;
  localparam int NumRegs  = 19;

  typedef enum logic [2:0] {
    CMD_RD_WORD  = 3'd0,
    CMD_WR_WORD  = 3'd1,
    CMD_RD_BYTE  = 3'd2,
    CMD_WR_BYTE  = 3'd3,
    CMD_SET_PINS = 3'd4,
    CMD_QUERY    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_DR  = 3'd0,
    KIND_DIR = 3'd1,
    KIND_CR1 = 3'd2,
    KIND_CR2 = 3'd3,
    KIND_PF  = 3'd4,
    KIND_NONE = 3'd5
  } kind_t;

  localparam logic CFG_SMALL_DEVICE = 1'b0;
  localparam logic CFG_OP_MODE      = 1'b1;

  localparam logic [1:0] MODE_EXT_ROM = 2'd2;
  localparam logic [1:0] MODE_SINGLE  = 2'd3;

  localparam logic [5:0] FN_NONE   = 6'd0;
  localparam logic [5:0] FN_GPIO   = 6'd1;
  localparam logic [5:0] FN_RSV    = 6'd2;
  localparam logic [5:0] FN_CK     = 6'd3;
  localparam logic [5:0] FN_RD     = 6'd4;
  localparam logic [5:0] FN_WRH    = 6'd5;
  localparam logic [5:0] FN_WRL    = 6'd6;
  localparam logic [5:0] FN_CS0    = 6'd7;
  localparam logic [5:0] FN_CS1    = 6'd8;
  localparam logic [5:0] FN_CS2    = 6'd9;
  localparam logic [5:0] FN_CS3    = 6'd10;
  localparam logic [5:0] FN_ADDR   = 6'd11;
  localparam logic [5:0] FN_DATA   = 6'd12;
  localparam logic [5:0] FN_RDWR   = 6'd13;
  localparam logic [5:0] FN_RAS    = 6'd14;
  localparam logic [5:0] FN_CASH   = 6'd15;
  localparam logic [5:0] FN_CASL   = 6'd16;
  localparam logic [5:0] FN_WAIT   = 6'd17;
  localparam logic [5:0] FN_AH     = 6'd18;
  localparam logic [5:0] FN_DREQ0  = 6'd19;
  localparam logic [5:0] FN_DREQ1  = 6'd20;
  localparam logic [5:0] FN_DACK0  = 6'd21;
  localparam logic [5:0] FN_DACK1  = 6'd22;
  localparam logic [5:0] FN_DRAK0  = 6'd23;
  localparam logic [5:0] FN_DRAK1  = 6'd24;
  localparam logic [5:0] FN_TCLKA  = 6'd25;
  localparam logic [5:0] FN_TCLKB  = 6'd26;
  localparam logic [5:0] FN_TCLKC  = 6'd27;
  localparam logic [5:0] FN_TCLKD  = 6'd28;
  localparam logic [5:0] FN_IRQ0   = 6'd29;
  localparam logic [5:0] FN_IRQ1   = 6'd30;
  localparam logic [5:0] FN_IRQ2   = 6'd31;
  localparam logic [5:0] FN_IRQ3   = 6'd32;
  localparam logic [5:0] FN_IRQ6   = 6'd35;
  localparam logic [5:0] FN_IRQ7   = 6'd36;
  localparam logic [5:0] FN_SCK0   = 6'd37;
  localparam logic [5:0] FN_SCK1   = 6'd38;
  localparam logic [5:0] FN_TXD0   = 6'd39;
  localparam logic [5:0] FN_TXD1   = 6'd40;
  localparam logic [5:0] FN_RXD0   = 6'd41;
  localparam logic [5:0] FN_RXD1   = 6'd42;
  localparam logic [5:0] FN_TIOC0A = 6'd43;
  localparam logic [5:0] FN_TIOC0B = 6'd44;
  localparam logic [5:0] FN_TIOC0C = 6'd45;
  localparam logic [5:0] FN_TIOC0D = 6'd46;
  localparam logic [5:0] FN_TIOC1A = 6'd47;
  localparam logic [5:0] FN_TIOC1B = 6'd48;
  localparam logic [5:0] FN_TIOC2A = 6'd49;
  localparam logic [5:0] FN_TIOC2B = 6'd50;

  localparam logic [15:0] CR1_RESET_A = 16'h4000;

  function automatic logic [2:0] reg_port(input logic [4:0] r);
    case (r)
      5'd0, 5'd1, 5'd2, 5'd3:                return 3'd0;
      5'd4, 5'd6, 5'd8, 5'd9:                return 3'd1;
      5'd5, 5'd7, 5'd10:                     return 3'd2;
      5'd11, 5'd12, 5'd13:                   return 3'd3;
      5'd14, 5'd16, 5'd17, 5'd18:            return 3'd4;
      default:                               return 3'd5;
    endcase
  endfunction

  function automatic kind_t reg_kind(input logic [4:0] r);
    case (r)
      5'd0, 5'd4, 5'd5, 5'd11, 5'd14: return KIND_DR;
      5'd1, 5'd6, 5'd7, 5'd12, 5'd16: return KIND_DIR;
      5'd2, 5'd8, 5'd17:              return KIND_CR1;
      5'd3, 5'd9, 5'd10, 5'd13, 5'd18: return KIND_CR2;
      5'd15:                          return KIND_PF;
      default:                        return KIND_NONE;
    endcase
  endfunction

  function automatic logic [15:0] present_mask(input logic [2:0] p, input logic s);
    case (p)
      3'd0:       return s ? 16'h83FF : 16'hFFFF;
      3'd1:       return s ? 16'h03FC : 16'h03FF;
      3'd2, 3'd3: return s ? 16'h0000 : 16'hFFFF;
      3'd4:       return 16'hFFFF;
      default:    return 16'h00FF;
    endcase
  endfunction

  function automatic logic [15:0] ctl1_wr_mask(input logic [2:0] p, input logic s);
    case (p)
      3'd0:    return s ? 16'h400F : 16'h555F;
      3'd1:    return 16'h000F;
      3'd4:    return 16'hF000;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] ctl2_wr_mask(input logic [2:0] p, input logic s);
    case (p)
      3'd0:       return 16'hFD75;
      3'd1:       return s ? 16'hFFF0 : 16'hFFF5;
      3'd2, 3'd3: return 16'hFFFF;
      3'd4:       return 16'h55FF;
      default:    return 16'h0000;
    endcase
  endfunction

  function automatic logic [5:0] sel2(input logic [1:0] v, input logic [5:0] f1,
                                      input logic [5:0] f2, input logic [5:0] f3);
    case (v)
      2'd1:    return f1;
      2'd2:    return f2;
      2'd3:    return f3;
      default: return FN_GPIO;
    endcase
  endfunction

  function automatic logic [5:0] sel1(input logic v, input logic [5:0] f);
    return v ? f : FN_GPIO;
  endfunction

  function automatic logic [5:0] decode_pin(input logic [2:0] p, input logic [3:0] pin,
                                            input logic [15:0] c1, input logic [15:0] c2);
    logic [5:0] f;
    f = FN_GPIO;
    case (p)
      3'd0: begin
        case (pin)
          4'd15: f = sel1(c1[14], FN_CK);
          4'd14: f = sel1(c1[12], FN_RD);
          4'd13: f = sel1(c1[10], FN_WRH);
          4'd12: f = sel1(c1[8], FN_WRL);
          4'd11: f = sel1(c1[6], FN_CS1);
          4'd10: f = sel1(c1[4], FN_CS0);
          4'd9:  f = sel2(c1[3:2], FN_TCLKD, FN_IRQ3, FN_RSV);
          4'd8:  f = sel2(c1[1:0], FN_TCLKC, FN_IRQ2, FN_RSV);
          4'd7:  f = sel2(c2[15:14], FN_TCLKB, FN_CS3, FN_RSV);
          4'd6:  f = sel2(c2[13:12], FN_TCLKA, FN_CS2, FN_RSV);
          4'd5:  f = sel2(c2[11:10], FN_SCK1, FN_DREQ1, FN_IRQ1);
          4'd4:  f = sel1(c2[8], FN_TXD1);
          4'd3:  f = sel1(c2[6], FN_RXD1);
          4'd2:  f = sel2(c2[5:4], FN_SCK0, FN_DREQ0, FN_IRQ0);
          4'd1:  f = sel1(c2[2], FN_TXD0);
          default: f = sel1(c2[0], FN_RXD0);
        endcase
      end
      3'd1: begin
        case (pin)
          4'd9: f = sel2(c1[3:2], FN_IRQ7, FN_ADDR, FN_RSV);
          4'd8: f = sel2(c1[1:0], FN_IRQ6, FN_ADDR, FN_WAIT);
          4'd7: f = sel2(c2[15:14], FN_RSV, FN_ADDR, FN_RSV);
          4'd6: f = sel2(c2[13:12], FN_RSV, FN_ADDR, FN_RSV);
          4'd5: f = sel2(c2[11:10], FN_IRQ3, FN_RSV, FN_RDWR);
          4'd4: f = sel2(c2[9:8], FN_IRQ2, FN_RSV, FN_CASH);
          4'd3: f = sel2(c2[7:6], FN_IRQ1, FN_RSV, FN_CASL);
          4'd2: f = sel2(c2[5:4], FN_IRQ0, FN_RSV, FN_RAS);
          4'd1: f = sel1(c2[2], FN_ADDR);
          default: f = sel1(c2[0], FN_ADDR);
        endcase
      end
      3'd2: f = sel1(c2[pin], FN_ADDR);
      3'd3: f = sel1(c2[pin], FN_DATA);
      3'd4: begin
        case (pin)
          4'd15: f = sel2(c1[15:14], FN_RSV, FN_DACK1, FN_RSV);
          4'd14: f = sel2(c1[13:12], FN_RSV, FN_DACK0, FN_AH);
          4'd7:  f = sel1(c2[14], FN_TIOC2B);
          4'd6:  f = sel1(c2[12], FN_TIOC2A);
          4'd5:  f = sel1(c2[10], FN_TIOC1B);
          4'd4:  f = sel1(c2[8], FN_TIOC1A);
          4'd3:  f = sel2(c2[7:6], FN_TIOC0D, FN_DRAK1, FN_RSV);
          4'd2:  f = sel2(c2[5:4], FN_TIOC0C, FN_DREQ1, FN_RSV);
          4'd1:  f = sel2(c2[3:2], FN_TIOC0B, FN_DRAK0, FN_RSV);
          4'd0:  f = sel2(c2[1:0], FN_TIOC0A, FN_DREQ0, FN_RSV);
          default: f = FN_GPIO;
        endcase
      end
      default: f = FN_GPIO;
    endcase
    return f;
  endfunction

  function automatic logic [5:0] pin_function(input logic [2:0] p, input logic [3:0] pin,
                                              input logic s, input logic [1:0] mode,
                                              input logic [15:0] c1, input logic [15:0] c2);
    logic [15:0] pm;
    logic [5:0]  f;
    pm = present_mask(p, s);
    f = decode_pin(p, pin, c1, c2);
    if (!pm[pin]) begin
      f = FN_NONE;
    end else if (mode < MODE_EXT_ROM && p == 3'd0 && pin >= 4'd10 && pin <= 4'd14) begin
      case (pin)
        4'd14:   f = FN_RD;
        4'd13:   f = FN_WRH;
        4'd12:   f = FN_WRL;
        4'd11:   f = FN_CS1;
        default: f = FN_CS0;
      endcase
    end else if (mode < MODE_EXT_ROM && p == 3'd1 && pin <= 4'd1) begin
      f = FN_ADDR;
    end else if (mode < MODE_EXT_ROM && p == 3'd2) begin
      f = FN_ADDR;
    end else if (mode < MODE_EXT_ROM && p == 3'd3) begin
      f = FN_DATA;
    end else if (mode == MODE_SINGLE && f >= FN_RD && f <= FN_DRAK1) begin
      f = FN_GPIO;
    end
    return f;
  endfunction

endpackage

// ----- hw/rtl/iopfc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I/O port pin function controller channels
// Valid/ready channel interfaces for commands, results and configuration.
// ----------------------------------------------------------------------------
interface iopfc_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [4:0]  reg_index;
  logic        byte_lane;
  logic [15:0] write_data;
  logic [2:0]  port_sel;
  logic [3:0]  pin_index;
  modport source (output valid, command, reg_index, byte_lane, write_data, port_sel,
                  pin_index, input ready);
  modport sink (input valid, command, reg_index, byte_lane, write_data, port_sel,
                pin_index, output ready);
endinterface

interface iopfc_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic [5:0]  function_code;
  logic [15:0] port_levels;
  modport source (output valid, read_data, function_code, port_levels, input ready);
  modport sink (input valid, read_data, function_code, port_levels, output ready);
endinterface

interface iopfc_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/io_port_pin_function_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I/O port pin function controller
// Six port register file with masked word/byte access and pin function query.
// ----------------------------------------------------------------------------
//   Channel | Dir | Contents
//   cmd     | in  | command, reg_index, byte_lane, write_data, port_sel, pin_index
//   rsp     | out | read_data, function_code, port_levels
//   cfg     | in  | index (0 small_device, 1 op_mode), data
// One item is taken per cycle; its result appears in the output register on
// the next cycle. The register file updates in the same cycle the item is taken.
// A stalled result holds its register; a new item is taken only when the output
// register is empty or being drained. Sync reset clears all ports but port 0 CR1.
module io_port_pin_function_controller (
  input logic clk,
  input logic rst,
  iopfc_cmd_if.sink   cmd,
  iopfc_rsp_if.source rsp,
  iopfc_cfg_if.sink   cfg
);
  import iopfc_pkg::*;

  logic        small_device;
  logic [1:0]  op_mode;
  logic [15:0] data_latch [NumPorts];
  logic [15:0] direction [NumPorts];
  logic [15:0] control_one [NumPorts];
  logic [15:0] control_two [NumPorts];
  logic [15:0] external_pins [NumPorts];
  logic        out_valid;
  logic [15:0] read_data;
  logic [5:0]  function_code;
  logic [15:0] port_levels;

  logic        take;
  logic [2:0]  rp;
  kind_t       rk;
  logic        r_ok;
  logic [15:0] rword;
  logic [15:0] wval;
  logic [15:0] cur;
  logic [15:0] pm;
  logic [15:0] rd_next;
  logic [5:0]  fn_next;
  logic [15:0] lv_next;
  logic [2:0]  qp;
  logic        q_ok;
  logic [15:0] gp;
  logic [15:0] outb;

  assign cmd.ready = !out_valid || rsp.ready;
  assign take = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.read_data = read_data;
  assign rsp.function_code = function_code;
  assign rsp.port_levels = port_levels;

  always_comb begin
    rp = reg_port(cmd.reg_index);
    rk = reg_kind(cmd.reg_index);
    pm = present_mask(rp, small_device);
    r_ok = (rk != KIND_NONE) && !((rp == 3'd2 || rp == 3'd3) && small_device);
    case (rk)
      KIND_DR:  rword = ((data_latch[rp] & direction[rp]) |
                         (external_pins[rp] & ~direction[rp])) & pm;
      KIND_DIR: rword = direction[rp];
      KIND_CR1: rword = control_one[rp];
      KIND_CR2: rword = control_two[rp];
      default:  rword = external_pins[rp] & pm;
    endcase
    if (!r_ok) rword = 16'hFFFF;
    case (rk)
      KIND_DR:  cur = data_latch[rp];
      KIND_DIR: cur = direction[rp];
      KIND_CR1: cur = control_one[rp];
      default:  cur = control_two[rp];
    endcase
    if (cmd.command == CMD_WR_BYTE) begin
      wval = cmd.byte_lane ? {cur[15:8], cmd.write_data[7:0]} :
                             {cmd.write_data[7:0], cur[7:0]};
    end else begin
      wval = cmd.write_data;
    end
    case (rk)
      KIND_CR1: wval = wval & ctl1_wr_mask(rp, small_device);
      KIND_CR2: wval = wval & ctl2_wr_mask(rp, small_device);
      default:  wval = wval & pm;
    endcase

    qp = (cmd.port_sel < 3'd6) ? cmd.port_sel : 3'd5;
    q_ok = cmd.port_sel < 3'd6;
    for (int i = 0; i < 16; i++) begin
      gp[i] = pin_function(qp, 4'(i), small_device, op_mode, control_one[qp],
                           control_two[qp]) == FN_GPIO;
    end
    outb = direction[qp] & gp;

    rd_next = '0;
    fn_next = FN_NONE;
    lv_next = '0;
    case (cmd.command)
      CMD_RD_WORD: rd_next = rword;
      CMD_RD_BYTE: rd_next = cmd.byte_lane ? {8'h00, rword[7:0]} : {8'h00, rword[15:8]};
      CMD_QUERY: begin
        if (q_ok) begin
          fn_next = pin_function(qp, cmd.pin_index, small_device, op_mode,
                                 control_one[qp], control_two[qp]);
          lv_next = ((data_latch[qp] & outb) | (external_pins[qp] & ~outb)) &
                    present_mask(qp, small_device);
        end
      end
      default: rd_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      small_device <= 1'b0;
      op_mode <= MODE_EXT_ROM;
      out_valid <= 1'b0;
      for (int i = 0; i < NumPorts; i++) begin
        data_latch[i] <= '0;
        direction[i] <= '0;
        control_one[i] <= '0;
        control_two[i] <= '0;
        external_pins[i] <= '0;
      end
      control_one[0] <= CR1_RESET_A;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == CFG_SMALL_DEVICE) small_device <= cfg.data[0];
        else op_mode <= cfg.data;
      end
      if (take) begin
        out_valid <= 1'b1;
        read_data <= rd_next;
        function_code <= fn_next;
        port_levels <= lv_next;
        if ((cmd.command == CMD_WR_WORD || cmd.command == CMD_WR_BYTE) && r_ok) begin
          case (rk)
            KIND_DR:  data_latch[rp] <= wval;
            KIND_DIR: direction[rp] <= wval;
            KIND_CR1: control_one[rp] <= wval;
            KIND_CR2: control_two[rp] <= wval;
            default:  ;
          endcase
        end
        if (cmd.command == CMD_SET_PINS && q_ok) external_pins[qp] <= cmd.write_data;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rsp.ready |=> out_valid && $stable(read_data))
    else $error("result lost under stall");
  a_fn_query: assert property (@(posedge clk) disable iff (rst)
    take && cmd.command != CMD_QUERY |=> function_code == FN_NONE && port_levels == 16'h0)
    else $error("query fields set for non-query item");
  a_portf_ro: assert property (@(posedge clk) disable iff (rst)
    take && cmd.command != CMD_SET_PINS |=> $stable(external_pins[5]))
    else $error("port F pins changed without set pins");
endmodule
